// ----- rtl/core/scps_pkg.sv -----
// ============================================================================
// scps_pkg: spherical cap point select shared definitions
// Field widths, arithmetic widths, register indexes and stage control types.
// ============================================================================
package scps_pkg;

    // Parameter defaults
    localparam int POS_BITS_DEF  = 24;
    localparam int TYPE_BITS_DEF = 8;

    // Fixed field widths
    localparam int IDX_W      = 24;
    localparam int RSQ_W      = 52;
    localparam int NRM_W      = 16;
    localparam int COS_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 52;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_RSQ   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_RSQ   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_NORMAL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_HALF    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_TYPE = 3'd7;

    localparam logic signed [COS_W-1:0] COS_RESET = 16'sd16384;

    // Arithmetic widths. Any |offset| >= 2^NEAR_BITS puts the squared
    // distance at or above 2^52, which no outer radius can exceed.
    localparam int MAG_W     = 34;              // magnitude of widest offset
    localparam int NEAR_BITS = 26;
    localparam int TRIM_W    = NEAR_BITS + 1;   // signed offset used by dot
    localparam int PROD_W    = NRM_W + TRIM_W;  // one n*d term
    localparam int DOT_W     = PROD_W + 2;      // sum of three terms
    localparam int RSUM_W    = RSQ_W + 2;       // sum of three squares
    localparam int DM_W      = 43;              // |dot| when in range
    localparam int DM_LO_W   = 22;
    localparam int DM_HI_W   = DM_W - DM_LO_W;
    localparam int CC_W      = 31;              // cos^2, at most 2^30
    localparam int RSQ_LO_W  = 26;
    localparam int RSQ_HI_W  = RSQ_W - RSQ_LO_W;
    localparam int PH_W      = CC_W + RSQ_LO_W;
    localparam int DSQ_W     = 2 * DM_W;
    localparam int RC_W      = CC_W + RSQ_W;

    // Load enables of the cap compare stages
    typedef struct packed {
        logic s5;
        logic s6;
        logic s7;
    } t_cap_en;

    // Per-item flags entering the cap compare
    typedef struct packed {
        logic inr;      // type matches and distance within the shell
        logic dpos;     // dot > 0
        logic dzero;    // dot == 0
    } t_cap_flags;

endpackage

// ----- rtl/core/scps_cap_cmp.sv -----
// ============================================================================
// scps_cap_cmp: cap angle test
// Three stages: split products, wide sums, final compare against cos^2*r^2.
// ============================================================================
module scps_cap_cmp (
    input  logic                           i_clk,
    input  scps_pkg::t_cap_en              i_en,
    input  logic [scps_pkg::DM_W-1:0]      i_dm,      // |n.d|
    input  logic [scps_pkg::RSQ_W-1:0]     i_rsq,
    input  logic [scps_pkg::CC_W-1:0]      i_cc,      // cos^2
    input  logic                           i_cos_neg,
    input  scps_pkg::t_cap_flags           i_flags,
    output logic                           o_sel
);

    // stage 5: partial products
    logic [2*scps_pkg::DM_HI_W-1:0]                  r_hh;
    logic [scps_pkg::DM_HI_W+scps_pkg::DM_LO_W-1:0]  r_hl;
    logic [2*scps_pkg::DM_LO_W-1:0]                  r_ll;
    logic [scps_pkg::PH_W-1:0]                       r_rh;
    logic [scps_pkg::PH_W-1:0]                       r_rl;
    scps_pkg::t_cap_flags                            r_f5;

    // stage 6: full squares
    logic [scps_pkg::DSQ_W-1:0] r_dsq;
    logic [scps_pkg::DSQ_W-1:0] r_rc;
    scps_pkg::t_cap_flags       r_f6;

    // stage 7: result
    logic r_sel;

    logic [scps_pkg::DM_HI_W-1:0]  w_dh;
    logic [scps_pkg::DM_LO_W-1:0]  w_dl;
    logic [scps_pkg::DSQ_W-1:0]    n_dsq;
    logic [scps_pkg::DSQ_W-1:0]    n_rc;
    logic                          n_sel;

    assign w_dh = i_dm[scps_pkg::DM_W-1:scps_pkg::DM_LO_W];
    assign w_dl = i_dm[scps_pkg::DM_LO_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_hh <= w_dh * w_dh;
            r_hl <= w_dh * w_dl;
            r_ll <= w_dl * w_dl;
            r_rh <= i_cc * i_rsq[scps_pkg::RSQ_W-1:scps_pkg::RSQ_LO_W];
            r_rl <= i_cc * i_rsq[scps_pkg::RSQ_LO_W-1:0];
            r_f5 <= i_flags;
        end
    end

    // dm^2 = hh*2^44 + 2*hl*2^22 + ll ; cc*rsq = rh*2^26 + rl
    always_comb begin
        n_dsq = (scps_pkg::DSQ_W'(r_hh) << (2 * scps_pkg::DM_LO_W))
              + (scps_pkg::DSQ_W'(r_hl) << (scps_pkg::DM_LO_W + 1))
              + scps_pkg::DSQ_W'(r_ll);
        n_rc  = (scps_pkg::DSQ_W'(r_rh) << scps_pkg::RSQ_LO_W)
              + scps_pkg::DSQ_W'(r_rl);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s6) begin
            r_dsq <= n_dsq;
            r_rc  <= n_rc;
            r_f6  <= r_f5;
        end
    end

    // cos >= 0: dot > 0 and dot^2 > c^2 r^2
    // cos <  0: dot >= 0 or dot^2 < c^2 r^2
    always_comb begin
        if (i_cos_neg) begin
            n_sel = r_f6.inr && (r_f6.dpos || r_f6.dzero || (r_dsq < r_rc));
        end else begin
            n_sel = r_f6.inr && r_f6.dpos && (r_dsq > r_rc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s7) begin
            r_sel <= n_sel;
        end
    end

    assign o_sel = r_sel;

endmodule

// ----- rtl/core/spherical_cap_point_select.sv -----
// ============================================================================
// spherical_cap_point_select: spherical cap particle selector
// Flags particles of the wanted type whose offset from the centre lies in a
// shell and within a cone around the cap normal.
// ============================================================================
// Pipeline: 7 register stages; m_axis_tvalid is the last stage's valid.
// Throughput: one particle per cycle while m_axis_tready is high; each stage
//   holds under back-pressure and fills its bubbles, so a stall loses or
//   repeats nothing.
// Reset (synchronous, i_rst_n low): all stage valids cleared, registers back
//   to their defaults (centre 0, radii 0, normal 0, cos_half_angle 1.0, type 0).
// ============================================================================
module spherical_cap_point_select #(
    parameter int POS_BITS  = scps_pkg::POS_BITS_DEF,
    parameter int TYPE_BITS = scps_pkg::TYPE_BITS_DEF,
    localparam int IN_W =
        ((scps_pkg::IDX_W + TYPE_BITS + 3 * POS_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [scps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [scps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // particle stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: particle_index, particle_type, pos_x, pos_y, pos_z, zero pad
    input  logic [IN_W-1:0]                 s_axis_tdata,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: index_out
    output logic [scps_pkg::IDX_W-1:0]      m_axis_tdata,
    // tuser: selected
    output logic                            m_axis_tuser
);

    localparam int NSTG  = 7;
    localparam int DW    = POS_BITS + 1;   // exact offset width
    localparam int TY_LO = scps_pkg::IDX_W;
    localparam int PX_LO = TY_LO + TYPE_BITS;
    localparam int PY_LO = PX_LO + POS_BITS;
    localparam int PZ_LO = PY_LO + POS_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [POS_BITS-1:0]          r_cx, r_cy, r_cz;
    logic [scps_pkg::RSQ_W-1:0]          r_inner, r_outer;
    logic [3*scps_pkg::NRM_W-1:0]        r_normal;
    logic signed [scps_pkg::COS_W-1:0]   r_cos;
    logic [TYPE_BITS-1:0]                r_want;
    logic [scps_pkg::CC_W-1:0]           r_cc;      // cos^2, refreshed each cycle
    logic signed [2*scps_pkg::COS_W-1:0] w_cc_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
            r_inner  <= '0;
            r_outer  <= '0;
            r_normal <= '0;
            r_cos    <= scps_pkg::COS_RESET;
            r_want   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                scps_pkg::CFG_CENTRE_X:    r_cx     <= i_cfg_data[POS_BITS-1:0];
                scps_pkg::CFG_CENTRE_Y:    r_cy     <= i_cfg_data[POS_BITS-1:0];
                scps_pkg::CFG_CENTRE_Z:    r_cz     <= i_cfg_data[POS_BITS-1:0];
                scps_pkg::CFG_INNER_RSQ:   r_inner  <= i_cfg_data[scps_pkg::RSQ_W-1:0];
                scps_pkg::CFG_OUTER_RSQ:   r_outer  <= i_cfg_data[scps_pkg::RSQ_W-1:0];
                scps_pkg::CFG_CAP_NORMAL:  r_normal <= i_cfg_data[3*scps_pkg::NRM_W-1:0];
                scps_pkg::CFG_COS_HALF:    r_cos    <= i_cfg_data[scps_pkg::COS_W-1:0];
                scps_pkg::CFG_WANTED_TYPE: r_want   <= i_cfg_data[TYPE_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign w_cc_full = r_cos * r_cos;

    always_ff @(posedge i_clk) begin
        r_cc <= w_cc_full[scps_pkg::CC_W-1:0];
    end

    // ------------------------------------------------------------------
    // Stage control: a stage loads when empty or when its successor moves
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_rdy;

    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // identifier rides alongside the arithmetic
    logic [scps_pkg::IDX_W-1:0] r_idx [NSTG];

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_idx[0] <= s_axis_tdata[scps_pkg::IDX_W-1:0];
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_rdy[k]) begin
                r_idx[k] <= r_idx[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: offsets from the centre, type match
    // ------------------------------------------------------------------
    logic signed [POS_BITS-1:0] w_px, w_py, w_pz;
    logic signed [DW-1:0]       r_dx1, r_dy1, r_dz1;
    logic                       r_match1;

    assign w_px = s_axis_tdata[PX_LO +: POS_BITS];
    assign w_py = s_axis_tdata[PY_LO +: POS_BITS];
    assign w_pz = s_axis_tdata[PZ_LO +: POS_BITS];

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_dx1    <= DW'(w_px) - DW'(r_cx);
            r_dy1    <= DW'(w_py) - DW'(r_cy);
            r_dz1    <= DW'(w_pz) - DW'(r_cz);
            r_match1 <= (s_axis_tdata[TY_LO +: TYPE_BITS] == r_want);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares of the offsets and normal products
    // ------------------------------------------------------------------
    logic signed [scps_pkg::MAG_W-1:0]  w_ex, w_ey, w_ez;
    logic [scps_pkg::MAG_W-1:0]         w_mx, w_my, w_mz;
    logic signed [scps_pkg::TRIM_W-1:0] w_tx, w_ty, w_tz;
    logic signed [scps_pkg::NRM_W-1:0]  w_nx, w_ny, w_nz;
    logic                               n_far2;

    logic [scps_pkg::RSQ_W-1:0]         r_sqx2, r_sqy2, r_sqz2;
    logic signed [scps_pkg::PROD_W-1:0] r_px2, r_py2, r_pz2;
    logic                               r_far2, r_match2;

    assign w_ex = scps_pkg::MAG_W'(r_dx1);
    assign w_ey = scps_pkg::MAG_W'(r_dy1);
    assign w_ez = scps_pkg::MAG_W'(r_dz1);
    assign w_mx = w_ex[scps_pkg::MAG_W-1] ? scps_pkg::MAG_W'(-w_ex) : w_ex;
    assign w_my = w_ey[scps_pkg::MAG_W-1] ? scps_pkg::MAG_W'(-w_ey) : w_ey;
    assign w_mz = w_ez[scps_pkg::MAG_W-1] ? scps_pkg::MAG_W'(-w_ez) : w_ez;

    // far offsets only feed a result that is forced unselected,
    // so the dot terms may use the trimmed value
    assign w_tx = scps_pkg::TRIM_W'(r_dx1);
    assign w_ty = scps_pkg::TRIM_W'(r_dy1);
    assign w_tz = scps_pkg::TRIM_W'(r_dz1);

    assign w_nx = r_normal[0 +: scps_pkg::NRM_W];
    assign w_ny = r_normal[scps_pkg::NRM_W +: scps_pkg::NRM_W];
    assign w_nz = r_normal[2*scps_pkg::NRM_W +: scps_pkg::NRM_W];

    assign n_far2 = (|w_mx[scps_pkg::MAG_W-1:scps_pkg::NEAR_BITS])
                 || (|w_my[scps_pkg::MAG_W-1:scps_pkg::NEAR_BITS])
                 || (|w_mz[scps_pkg::MAG_W-1:scps_pkg::NEAR_BITS]);

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_sqx2   <= w_mx[scps_pkg::NEAR_BITS-1:0] * w_mx[scps_pkg::NEAR_BITS-1:0];
            r_sqy2   <= w_my[scps_pkg::NEAR_BITS-1:0] * w_my[scps_pkg::NEAR_BITS-1:0];
            r_sqz2   <= w_mz[scps_pkg::NEAR_BITS-1:0] * w_mz[scps_pkg::NEAR_BITS-1:0];
            r_px2    <= w_nx * w_tx;
            r_py2    <= w_ny * w_ty;
            r_pz2    <= w_nz * w_tz;
            r_far2   <= n_far2;
            r_match2 <= r_match1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squared distance and dot product sums
    // ------------------------------------------------------------------
    logic [scps_pkg::RSUM_W-1:0]       r_rsq3;
    logic signed [scps_pkg::DOT_W-1:0] r_dot3;
    logic                              r_far3, r_match3;

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_rsq3   <= scps_pkg::RSUM_W'(r_sqx2) + scps_pkg::RSUM_W'(r_sqy2)
                      + scps_pkg::RSUM_W'(r_sqz2);
            r_dot3   <= scps_pkg::DOT_W'(r_px2) + scps_pkg::DOT_W'(r_py2)
                      + scps_pkg::DOT_W'(r_pz2);
            r_far3   <= r_far2;
            r_match3 <= r_match2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: shell test, |dot| and its sign
    // ------------------------------------------------------------------
    logic [scps_pkg::RSQ_W-1:0] w_rsq3;
    logic                       n_inr4;
    logic [scps_pkg::DM_W-1:0]  n_dm4;

    logic [scps_pkg::DM_W-1:0]  r_dm4;
    logic [scps_pkg::RSQ_W-1:0] r_rsq4;
    logic                       r_inr4, r_dpos4, r_dzero4;

    assign w_rsq3 = r_rsq3[scps_pkg::RSQ_W-1:0];

    // a sum at or past 2^52 is beyond any outer bound
    assign n_inr4 = r_match3 && !r_far3
                 && !(|r_rsq3[scps_pkg::RSUM_W-1:scps_pkg::RSQ_W])
                 && (r_inner < w_rsq3) && (w_rsq3 < r_outer);

    assign n_dm4 = r_dot3[scps_pkg::DOT_W-1] ? scps_pkg::DM_W'(-r_dot3)
                                             : scps_pkg::DM_W'(r_dot3);

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_dm4    <= n_dm4;
            r_rsq4   <= w_rsq3;
            r_inr4   <= n_inr4;
            r_dpos4  <= !r_dot3[scps_pkg::DOT_W-1] && (r_dot3 != '0);
            r_dzero4 <= (r_dot3 == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stages 5..7: cone test
    // ------------------------------------------------------------------
    scps_pkg::t_cap_en    w_cap_en;
    scps_pkg::t_cap_flags w_cap_flags;
    logic                 w_sel;

    assign w_cap_en.s5       = w_rdy[4];
    assign w_cap_en.s6       = w_rdy[5];
    assign w_cap_en.s7       = w_rdy[6];
    assign w_cap_flags.inr   = r_inr4;
    assign w_cap_flags.dpos  = r_dpos4;
    assign w_cap_flags.dzero = r_dzero4;

    scps_cap_cmp u_cap_cmp (
        .i_clk     (i_clk),
        .i_en      (w_cap_en),
        .i_dm      (r_dm4),
        .i_rsq     (r_rsq4),
        .i_cc      (r_cc),
        .i_cos_neg (r_cos[scps_pkg::COS_W-1]),
        .i_flags   (w_cap_flags),
        .o_sel     (w_sel)
    );

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign s_axis_tready = w_rdy[0];
    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = r_idx[NSTG-1];
    assign m_axis_tuser  = w_sel;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // input only backs up once every stage is occupied
    a_full_before_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&r_vld))
        else $error("input stalled while a stage was empty");

    // a held stage 4 keeps its valid, |dot| and shell flag
    a_stage4_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && !w_rdy[3]) |=> (r_vld[3] && $stable(r_dm4) && $stable(r_inr4)))
        else $error("stage 4 item changed while stalled");

    // a far particle never reaches the cone test as in range
    a_far_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rdy[3] && r_vld[2] && r_far3) |=> !r_inr4)
        else $error("far particle passed the shell test");

endmodule
